/* design/lpfd_pkg.sv */
// Package: types and constants shared by the length-prefixed field deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

  // Bytes in one big-endian length header
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned LEN_W     = 8 * HDR_BYTES;
  localparam int unsigned FIELD_W   = 3;

  // End-of-payload report codes
  typedef enum logic [1:0] {
    STATUS_BUSY      = 2'd0,
    STATUS_ACCEPTED  = 2'd1,
    STATUS_TRUNCATED = 2'd2,
    STATUS_TRAILING  = 2'd3
  } status_t;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  // Result word
  typedef struct packed {
    logic [7:0]         out_byte;
    logic [FIELD_W-1:0] field_number;
    logic               content_valid;
    logic               field_done;
    status_t            status;
  } result_t;

  // Parser state carried from word to word
  typedef struct packed {
    logic [FIELD_W-1:0] current_field;
    logic [1:0]         header_bytes_seen;
    logic               in_content;
    logic [LEN_W-1:0]   length_or_remaining;
    logic               all_fields_done;
    logic               trailing_seen;
  } parse_state_t;

endpackage

/* design/lpfd_step.sv */
// Module: per-word parse step, next parser state and result for one input word.
`timescale 1ns / 1ps

module lpfd_step #(
  parameter int unsigned FIELD_COUNT = 5
) (
  input  lpfd_pkg::parse_state_t st,
  input  lpfd_pkg::item_t        item,
  output lpfd_pkg::parse_state_t st_next,
  output lpfd_pkg::result_t      res
);
  import lpfd_pkg::*;

  localparam logic [FIELD_W:0] LAST_FIELD_PLUS1 = (FIELD_W+1)'(FIELD_COUNT);

  logic [LEN_W-1:0]   shifted;
  logic [LEN_W-1:0]   dec;
  logic               finish;
  parse_state_t       work;

  assign shifted = {st.length_or_remaining[LEN_W-9:0], item.data_byte};
  assign dec     = st.length_or_remaining - LEN_W'(1);

  always_comb begin
    work   = st;
    res    = '0;
    finish = 1'b0;

    // Header gathering, content tagging, or trailing bytes
    if (st.all_fields_done) begin
      work.trailing_seen = 1'b1;
    end else if (!st.in_content) begin
      work.length_or_remaining = shifted;
      if (st.header_bytes_seen == 2'(HDR_BYTES - 1)) begin
        work.header_bytes_seen = '0;
        if (shifted == '0) begin
          res.field_done   = 1'b1;
          res.field_number = st.current_field;
          finish           = 1'b1;
        end else begin
          work.in_content = 1'b1;
        end
      end else begin
        work.header_bytes_seen = st.header_bytes_seen + 2'd1;
      end
    end else begin
      res.out_byte             = item.data_byte;
      res.content_valid        = 1'b1;
      res.field_number         = st.current_field;
      work.length_or_remaining = dec;
      if (dec == '0) begin
        res.field_done = 1'b1;
        finish         = 1'b1;
      end
    end

    // Field end: advance to the next field or close the frame
    if (finish) begin
      work.in_content          = 1'b0;
      work.header_bytes_seen   = '0;
      work.length_or_remaining = '0;
      if ({1'b0, st.current_field} + (FIELD_W+1)'(1) >= LAST_FIELD_PLUS1) begin
        work.all_fields_done = 1'b1;
        work.current_field   = '0;
      end else begin
        work.current_field = st.current_field + FIELD_W'(1);
      end
    end

    // Final byte: report and clear for the next payload
    st_next = work;
    if (item.last) begin
      priority if (!work.all_fields_done) begin
        res.status = STATUS_TRUNCATED;
      end else if (work.trailing_seen) begin
        res.status = STATUS_TRAILING;
      end else begin
        res.status = STATUS_ACCEPTED;
      end
      st_next = '0;
    end
  end

endmodule

/* design/length_prefixed_field_deframer_core.sv */
// Module: top level of the length-prefixed field deframer.
`timescale 1ns / 1ps

//  channel | dir | handshake                  | word
//  --------+-----+----------------------------+---------------------------------
//  item    | in  | item_valid / item_stall    | data_byte, last
//  result  | out | result_valid / result_stall| out_byte, field_number, flags, status
//
//  One result word per input word; one word per cycle sustained while result_stall is low.
//  The parse step feeds a single result register: a result appears in the cycle after its word is taken.
//  item_stall is high only while a held result is stalled downstream.
//  rst (synchronous) clears the parser state and the result valid flag.

module length_prefixed_field_deframer_core #(
  parameter int unsigned FIELD_COUNT = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lpfd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output lpfd_pkg::result_t result
);
  import lpfd_pkg::*;

  parse_state_t st;
  parse_state_t st_next;
  result_t      res_next;
  logic         take;

  // Accept whenever the result register is free or draining this cycle
  assign item_stall = result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  lpfd_step #(
    .FIELD_COUNT(FIELD_COUNT)
  ) u_step (
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
  end

`ifndef SYNTH
  // Final byte leaves the parser cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && item.last |=> st == '0)
    else $error("parser state not cleared after final byte");

  // While in content, bytes are still owed
  a_content_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.in_content |-> st.length_or_remaining != '0)
    else $error("content state with zero remaining length");

  // After the last field no header or content is open
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    st.all_fields_done |-> !st.in_content && st.header_bytes_seen == 2'd0)
    else $error("open field after all fields done");

  // Tagged words carry a legal field index
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.content_valid || result.field_done)
      |-> {1'b0, result.field_number} < (FIELD_W+1)'(FIELD_COUNT))
    else $error("field number out of range");
`endif

endmodule
